// File: hw/rtl/palette_lookup_pixel_packer_core_assert.svh
// Assertion macros shared by the queue and back end modules of the palette lookup pixel packer
`ifndef PALETTE_LOOKUP_PIXEL_PACKER_CORE_ASSERT_SVH
`define PALETTE_LOOKUP_PIXEL_PACKER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PLPP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plpp: same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define PLPP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plpp: next-cycle check failed");

`endif

// File: hw/rtl/plpp_pkg.sv
// Package: types, constants and pixel packing helpers of the palette pixel packer
package plpp_pkg;

	localparam int unsigned PALETTE_DEPTH_DEF = 256;
	localparam int unsigned QUEUE_DEPTH       = 4;

	// request op codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// channel masks of a palette word
	localparam logic [31:0] MASK_B8 = 32'h0000_00ff;
	localparam logic [31:0] MASK_G8 = 32'h0000_ff00;
	localparam logic [31:0] MASK_R8 = 32'h00ff_0000;
	localparam logic [31:0] MASK_R5 = 32'h00f8_0000;
	localparam logic [31:0] MASK_G6 = 32'h0000_fc00;
	localparam logic [31:0] MASK_G5 = 32'h0000_f800;
	localparam logic [31:0] MASK_B5 = 32'h0000_00f8;

	typedef enum logic [2:0] {
		FMT_ARGB32   = 3'd0,
		FMT_BGR24    = 3'd1,
		FMT_RGB16    = 3'd2,
		FMT_RGB15    = 3'd3,
		FMT_RGB16_SW = 3'd4,
		FMT_RGB15_SW = 3'd5,
		FMT_BGRA32   = 3'd6
	} fmt_t;

	// input request
	typedef struct packed {
		logic        op;
		logic [7:0]  entry_address;
		logic [31:0] entry_value;
		logic [7:0]  pixel_index;
		logic        end_of_row;
	} item_t;

	// output request
	typedef struct packed {
		logic [31:0] packed_word;
		logic        row_done;
	} word_t;

	// looked-up pixel handed from front to back
	typedef struct packed {
		logic [31:0] color;
		logic        end_of_row;
	} pix_t;

	function automatic logic [31:0] swap_bytes(input logic [31:0] v);
		return ((v & MASK_B8) << 24) | ((v & MASK_G8) << 8) |
			((v & MASK_R8) >> 8) | ((v >> 24) & MASK_B8);
	endfunction

	function automatic logic [31:0] hi565(input logic [31:0] v);
		return ((v & MASK_R5) << 8) | ((v & MASK_G6) << 11) | ((v & MASK_B5) << 13);
	endfunction

	function automatic logic [31:0] lo565(input logic [31:0] v);
		return ((v & MASK_R5) >> 8) | ((v & MASK_G6) >> 5) | ((v & MASK_B5) >> 3);
	endfunction

	function automatic logic [31:0] hi555(input logic [31:0] v);
		return ((v & MASK_R5) << 7) | ((v & MASK_G5) << 10) | ((v & MASK_B5) << 13);
	endfunction

	function automatic logic [31:0] lo555(input logic [31:0] v);
		return ((v & MASK_R5) >> 9) | ((v & MASK_G5) >> 6) | ((v & MASK_B5) >> 3);
	endfunction

endpackage

// File: hw/rtl/plpp_front.sv
// Front end: accepts requests, writes the palette, looks up pixel colors
module plpp_front import plpp_pkg::*; #(
	parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  pix_valid,
	input  logic  pix_full,
	output pix_t  pix
);

	localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [31:0] palette_mem [PALETTE_DEPTH];

	logic        accept;
	logic        advance;
	logic        wr_hit;
	logic        rd_hit;
	logic        pix_valid_s1;
	logic [31:0] color_s1;
	logic        hit_s1;
	logic        eor_s1;

	// lookup stage holds while the queue is full
	assign advance    = pix_valid_s1 && !pix_full;
	assign item_stall = pix_valid_s1 && pix_full;
	assign accept     = item_valid && !item_stall;

	assign wr_hit = {1'b0, item.entry_address} < 9'(PALETTE_DEPTH);
	assign rd_hit = {1'b0, item.pixel_index} < 9'(PALETTE_DEPTH);

	// palette write port
	always_ff @(posedge clk) begin
		if (accept && item.op == OP_WRITE && wr_hit) begin
			palette_mem[item.entry_address[AW-1:0]] <= item.entry_value;
		end
	end

	// palette read port, registered
	always_ff @(posedge clk) begin
		if (accept && item.op == OP_PIXEL) begin
			color_s1 <= palette_mem[item.pixel_index[AW-1:0]];
			hit_s1   <= rd_hit;
			eor_s1   <= item.end_of_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else if (accept && item.op == OP_PIXEL) begin
			pix_valid_s1 <= 1'b1;
		end else if (advance) begin
			pix_valid_s1 <= 1'b0;
		end
	end

	// an index beyond the palette reads as zero
	assign pix_valid       = pix_valid_s1;
	assign pix.color       = hit_s1 ? color_s1 : 32'h0;
	assign pix.end_of_row  = eor_s1;

endmodule

// File: hw/rtl/plpp_queue.sv
// Short pixel queue between the lookup front end and the packing back end
module plpp_queue import plpp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pix_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output pix_t head
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	pix_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`include "palette_lookup_pixel_packer_core_assert.svh"

	`PLPP_ASSERT_IMP(a_no_pop_empty, pop, !empty)
	`PLPP_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(QUEUE_DEPTH))

endmodule

// File: hw/rtl/plpp_back.sv
// Back end: packs looked-up pixels into destination words in the selected format
module plpp_back import plpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [2:0] cfg_wdata,
	input  logic       q_empty,
	input  pix_t       head,
	output logic       pop,
	output logic       word_valid,
	input  logic       word_stall,
	output word_t      word
);

	fmt_t        fmt_q;
	logic [1:0]  phase_q;
	logic [31:0] partial_q;
	logic        word_valid_q;
	word_t       word_q;

	logic [31:0] v;
	logic [1:0]  nphase;
	logic [31:0] npartial;
	logic [31:0] w;
	logic        emit;
	logic        grouped_fmt;

	// take a pixel when the output register is free or being drained
	assign pop = !q_empty && (!word_valid_q || !word_stall);
	assign v   = head.color;

	// formats that carry a group across pixels
	assign grouped_fmt = fmt_q == FMT_BGR24 || fmt_q == FMT_RGB16 || fmt_q == FMT_RGB15 ||
		fmt_q == FMT_RGB16_SW || fmt_q == FMT_RGB15_SW;

	// packing step
	always_comb begin
		nphase   = phase_q;
		npartial = partial_q;
		w        = 32'h0;
		emit     = 1'b0;
		unique case (fmt_q)
			FMT_BGR24: begin
				unique case (phase_q)
					2'd0: begin
						npartial = {v[7:0], v[15:8], v[23:16], 8'h00};
						nphase   = 2'd1;
					end
					2'd1: begin
						w        = partial_q | {24'h0, v[7:0]};
						npartial = {v[15:8], v[23:16], 16'h0};
						nphase   = 2'd2;
						emit     = !head.end_of_row;
					end
					2'd2: begin
						w        = partial_q | {16'h0, v[7:0], v[15:8]};
						npartial = {v[23:16], 24'h0};
						nphase   = 2'd3;
						emit     = !head.end_of_row;
					end
					default: begin
						w        = partial_q | {8'h0, v[7:0], v[15:8], v[23:16]};
						npartial = 32'h0;
						nphase   = 2'd0;
						emit     = 1'b1;
					end
				endcase
			end
			FMT_RGB16, FMT_RGB15, FMT_RGB16_SW, FMT_RGB15_SW: begin
				if (phase_q == 2'd0) begin
					unique case (fmt_q)
						FMT_RGB16:    npartial = hi565(v);
						FMT_RGB15:    npartial = hi555(v);
						FMT_RGB16_SW: npartial = lo565(v);
						default:      npartial = lo555(v);
					endcase
					nphase = 2'd1;
				end else begin
					unique case (fmt_q)
						FMT_RGB16:    w = partial_q | lo565(v);
						FMT_RGB15:    w = partial_q | lo555(v);
						FMT_RGB16_SW: w = swap_bytes(partial_q | hi565(v));
						default:      w = swap_bytes(partial_q | hi555(v));
					endcase
					nphase   = 2'd0;
					npartial = 32'h0;
					emit     = 1'b1;
				end
			end
			FMT_BGRA32: begin
				w    = swap_bytes(v);
				emit = 1'b1;
			end
			default: begin
				w    = v;
				emit = 1'b1;
			end
		endcase
		// row end restarts the group
		if (head.end_of_row) begin
			nphase   = 2'd0;
			npartial = 32'h0;
		end
	end

	// format register and packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= FMT_ARGB32;
			phase_q   <= 2'd0;
			partial_q <= 32'h0;
		end else if (cfg_wen) begin
			fmt_q     <= fmt_t'(cfg_wdata);
			phase_q   <= 2'd0;
			partial_q <= 32'h0;
		end else if (pop) begin
			phase_q   <= nphase;
			partial_q <= npartial;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (pop && emit) begin
			word_valid_q <= 1'b1;
		end else if (!word_stall) begin
			word_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			word_q.packed_word <= w;
			word_q.row_done    <= head.end_of_row;
		end
	end

	assign word_valid = word_valid_q;
	assign word       = word_q;

	`include "palette_lookup_pixel_packer_core_assert.svh"

	`PLPP_ASSERT_NXT(a_cfg_clears, cfg_wen, phase_q == 2'd0 && partial_q == 32'h0)
	`PLPP_ASSERT_IMP(a_phase_fmt, phase_q != 2'd0, grouped_fmt)
	`PLPP_ASSERT_NXT(a_single_emits, pop && (fmt_q == FMT_ARGB32 || fmt_q == FMT_BGRA32), word_valid_q)

endmodule

// File: hw/rtl/palette_lookup_pixel_packer_core.sv
// Top level: palette lookup pixel packer, front end, pixel queue and packing back end
// An accepted pixel passes the lookup register and the queue; its word, if any, leaves from the output register.
// Throughput: one request per cycle while the queue has room, set by the single palette read port and packing step.
// The four-entry queue lets the front keep accepting while the output is stalled, until it fills.
// Reset clears valid flags, queue pointers, format (argb32) and packing phase at once.
// Palette contents are undefined after reset until written; there is no clearing pass.
module palette_lookup_pixel_packer_core import plpp_pkg::*; #(
	parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [2:0] cfg_wdata,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       word_valid,
	input  logic       word_stall,
	output word_t      word
);

	logic pix_valid;
	logic q_full;
	logic q_empty;
	logic q_pop;
	pix_t pix;
	pix_t q_head;

	// lookup front end
	plpp_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.pix_valid  (pix_valid),
		.pix_full   (q_full),
		.pix        (pix)
	);

	// decoupling queue
	plpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pix_valid && !q_full),
		.push_data (pix),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// packing back end
	plpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.q_empty    (q_empty),
		.head       (q_head),
		.pop        (q_pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

endmodule

// File: tb/testbench.sv
// Testbench for palette_lookup_pixel_packer_core: palette loads and pixel packing in every format
`timescale 1ns / 100ps

module testbench;
	import plpp_pkg::*;

	// spare format code, handled as argb32
	localparam logic [2:0] FMT_SPARE = 3'd7;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF       = 16;
	localparam int TAIL_CYCLES    = 20;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wen;
	logic [2:0] cfg_wdata;
	logic       item_valid;
	logic       item_stall;
	item_t      item;
	logic       word_valid;
	logic       word_stall;
	word_t      word;

	palette_lookup_pixel_packer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

	// shadow of the palette and packing state
	logic [31:0] pal_shadow [256];
	logic        pal_loaded [256];
	logic [7:0]  loaded_idx [$];
	logic [2:0]  cur_fmt;
	logic [1:0]  pack_pos;
	logic [31:0] held_bits;
	word_t       exp_words [$];
	word_t       exp_head;

	int       errors;
	int       burst_left;
	int       idle_cycles;
	rx_mode_t rx_mode;
	int       rx_left;
	int       rx_tick;
	logic     rx_hold;
	logic     next_stall;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] bswap(input logic [31:0] c);
		return {c[7:0], c[15:8], c[23:16], c[31:24]};
	endfunction

	function automatic logic [15:0] px565(input logic [31:0] c);
		return {c[23:19], c[15:10], c[7:3]};
	endfunction

	function automatic logic [15:0] px555(input logic [31:0] c);
		return {1'b0, c[23:19], c[15:11], c[7:3]};
	endfunction

	// expected word (if any) for one accepted request
	function automatic void predict_request(input item_t r);
		logic [31:0] c;
		logic [31:0] w;
		logic [15:0] p;
		logic        emit;
		word_t       e;
		w = '0;
		emit = 1'b0;
		if (r.op == OP_WRITE) begin
			pal_shadow[r.entry_address] = r.entry_value;
			if (!pal_loaded[r.entry_address]) begin
				pal_loaded[r.entry_address] = 1'b1;
				loaded_idx.push_back(r.entry_address);
			end
			return;
		end
		c = pal_shadow[r.pixel_index];
		unique case (cur_fmt)
			FMT_BGR24: begin
				// four pixels of B,G,R bytes into three words
				unique case (pack_pos)
					2'd0: held_bits = {c[7:0], c[15:8], c[23:16], 8'h00};
					2'd1: begin
						w = {held_bits[31:8], c[7:0]};
						held_bits = {c[15:8], c[23:16], 16'h0000};
						emit = !r.end_of_row;
					end
					2'd2: begin
						w = {held_bits[31:16], c[7:0], c[15:8]};
						held_bits = {c[23:16], 24'h000000};
						emit = !r.end_of_row;
					end
					default: begin
						w = {held_bits[31:24], c[7:0], c[15:8], c[23:16]};
						held_bits = '0;
						emit = 1'b1;
					end
				endcase
				pack_pos = pack_pos + 2'd1;
			end
			FMT_RGB16, FMT_RGB15, FMT_RGB16_SW, FMT_RGB15_SW: begin
				p = (cur_fmt == FMT_RGB16 || cur_fmt == FMT_RGB16_SW) ? px565(c) : px555(c);
				if (pack_pos == 2'd0) begin
					held_bits = (cur_fmt == FMT_RGB16 || cur_fmt == FMT_RGB15) ?
						{p, 16'h0000} : {16'h0000, p};
					pack_pos = 2'd1;
				end else begin
					if (cur_fmt == FMT_RGB16 || cur_fmt == FMT_RGB15)
						w = {held_bits[31:16], p};
					else
						w = bswap({p, held_bits[15:0]});
					pack_pos = 2'd0;
					held_bits = '0;
					emit = 1'b1;
				end
			end
			FMT_BGRA32: begin
				w = bswap(c);
				emit = 1'b1;
			end
			default: begin
				w = c;
				emit = 1'b1;
			end
		endcase
		// row end always restarts the group
		if (r.end_of_row) begin
			pack_pos = 2'd0;
			held_bits = '0;
		end
		if (emit) begin
			e.packed_word = w;
			e.row_done = r.end_of_row;
			exp_words.push_back(e);
		end
	endfunction

	function automatic item_t pixel_req(input logic [7:0] idx, input logic eor);
		item_t r;
		r.op = OP_PIXEL;
		r.entry_address = 8'($urandom);
		r.entry_value = $urandom;
		r.pixel_index = idx;
		r.end_of_row = eor;
		return r;
	endfunction

	function automatic item_t write_req(input logic [7:0] addr, input logic [31:0] value,
			input logic eor);
		item_t r;
		r.op = OP_WRITE;
		r.entry_address = addr;
		r.entry_value = value;
		r.pixel_index = 8'($urandom);
		r.end_of_row = eor;
		return r;
	endfunction

	// only entries already loaded are ever looked up
	function automatic logic [7:0] pick_index();
		return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
	endfunction

	function automatic logic [31:0] color_word();
		int sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return 32'h0000_0000;
		else if (sel == 1)
			return 32'hffff_ffff;
		return $urandom;
	endfunction

	// send one request; sender runs in bursts with gaps in between
	task automatic send_req(input item_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= r;
		do @(posedge clk); while (item_stall);
		predict_request(r);
	endtask

	// pause until every expected word is out, then let the pipe settle
	task automatic drain_outputs();
		item_valid <= 1'b0;
		while (exp_words.size() != 0) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_OFF) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	task automatic set_format(input logic [2:0] f);
		drain_outputs();
		cfg_wen <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cur_fmt = f;
		pack_pos = 2'd0;
		held_bits = '0;
	endtask

	// corner entries and values; end_of_row on a write is ignored
	task automatic test_palette_load();
		send_req(write_req(8'd0, 32'h0000_0000, 1'b0));
		send_req(write_req(8'd255, 32'hffff_ffff, 1'b1));
		send_req(write_req(8'd1, 32'h3c96_e15a, 1'b0));
		send_req(write_req(8'd128, 32'h807f_01fe, 1'b1));
	endtask

	// full quad with row end, then a quad cut at its third pixel
	task automatic test_bgr24_quads();
		set_format(FMT_BGR24);
		send_req(pixel_req(8'd1, 1'b0));
		send_req(pixel_req(8'd255, 1'b0));
		send_req(pixel_req(8'd128, 1'b0));
		send_req(pixel_req(8'd0, 1'b1));
		send_req(pixel_req(8'd255, 1'b0));
		send_req(pixel_req(8'd1, 1'b0));
		send_req(pixel_req(8'd0, 1'b1));
	endtask

	// palette write inside a pair, then a pair cut by row end
	task automatic test_pair_formats();
		set_format(FMT_RGB16_SW);
		send_req(pixel_req(8'd1, 1'b0));
		send_req(write_req(8'd2, 32'h5a5a_a5a5, 1'b1));
		send_req(pixel_req(8'd128, 1'b0));
		send_req(pixel_req(8'd255, 1'b1));
	endtask

	// one word per pixel formats, spare code included
	task automatic test_word_formats();
		set_format(FMT_SPARE);
		send_req(pixel_req(8'd255, 1'b0));
		send_req(pixel_req(8'd1, 1'b1));
		set_format(FMT_BGRA32);
		send_req(pixel_req(8'd128, 1'b1));
	endtask

	// random rows in every format, mostly whole groups, some cut short, some writes
	task automatic test_random_stream();
		logic [2:0] fmt_order [8];
		int a;
		int ph;
		int sent;
		int row_len;
		int grp;
		int k;
		fmt_order = '{FMT_BGR24, FMT_ARGB32, FMT_RGB16, FMT_RGB15,
			FMT_RGB16_SW, FMT_RGB15_SW, FMT_BGRA32, FMT_SPARE};
		for (a = 0; a < 256; a++)
			send_req(write_req(a[7:0], color_word(), 1'($urandom_range(0, 1))));
		for (ph = 0; ph < 16; ph++) begin
			set_format(ph < 8 ? fmt_order[ph] : 3'($urandom_range(0, 7)));
			if (cur_fmt == FMT_BGR24)
				grp = 4;
			else if (cur_fmt >= FMT_RGB16 && cur_fmt <= FMT_RGB15_SW)
				grp = 2;
			else
				grp = 1;
			sent = 0;
			while (sent < 64) begin
				if ($urandom_range(0, 99) < 8) begin
					send_req(write_req(8'($urandom), color_word(),
						1'($urandom_range(0, 1))));
					sent++;
				end else begin
					row_len = ($urandom_range(0, 3) != 0) ? grp * $urandom_range(1, 4) :
						$urandom_range(1, 9);
					for (k = 0; k < row_len; k++) begin
						if ($urandom_range(0, 15) == 0) begin
							send_req(write_req(8'($urandom), color_word(),
								1'($urandom_range(0, 1))));
							sent++;
						end
						send_req(pixel_req(pick_index(), k == row_len - 1));
						sent++;
					end
				end
			end
		end
	endtask

	// check each word against the oldest expectation, then pick the next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (word_valid && !word_stall) begin
				if (exp_words.size() == 0) begin
					$error("unexpected word: packed_word %h row_done %b",
						word.packed_word, word.row_done);
					errors++;
				end else begin
					exp_head = exp_words.pop_front();
					if (word.packed_word !== exp_head.packed_word) begin
						$error("packed_word: expected %h, actual %h",
							exp_head.packed_word, word.packed_word);
						errors++;
					end
					if (word.row_done !== exp_head.row_done) begin
						$error("row_done: expected %b, actual %b",
							exp_head.row_done, word.row_done);
						errors++;
					end
				end
			end
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 160);
			end else begin
				rx_left--;
			end
			rx_tick++;
			unique case (rx_mode)
				RX_FREE:  next_stall = 1'b0;
				RX_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
				RX_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
				default:  next_stall = (rx_tick % 5) < 2;
			endcase
			word_stall <= next_stall && !rx_hold;
		end
	end

	// watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (word_valid && !word_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = FMT_ARGB32;
		item_valid = 1'b0;
		item = '0;
		word_stall = 1'b0;
		errors = 0;
		burst_left = 0;
		idle_cycles = 0;
		rx_mode = RX_FREE;
		rx_left = 0;
		rx_tick = 0;
		rx_hold = 1'b0;
		cur_fmt = FMT_ARGB32;
		pack_pos = 2'd0;
		held_bits = '0;
		for (i = 0; i < 256; i++)
			pal_loaded[i] = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_palette_load();
		test_bgr24_quads();
		test_pair_formats();
		test_word_formats();
		test_random_stream();

		drain_outputs();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (exp_words.size() != 0) begin
			$error("%0d expected words never arrived", exp_words.size());
			errors++;
		end
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: palette_lookup_pixel_packer_core.f
+incdir+hw/rtl
hw/rtl/plpp_pkg.sv
hw/rtl/plpp_front.sv
hw/rtl/plpp_queue.sv
hw/rtl/plpp_back.sv
hw/rtl/palette_lookup_pixel_packer_core.sv
tb/testbench.sv
